// File: rtl/sit_pkg.sv
// Types and constants shared by the segment intersection test pipeline.
// Depends on nothing; every rtl module takes names from here by scope.
package sit_pkg;

  // Register indexes on the configuration port (paddr[2])
  localparam logic REG_CROSS_TOL = 1'b0;
  localparam logic REG_BOX_TOL   = 1'b1;

  localparam int unsigned IN_DATA_W  = 256;
  localparam int unsigned OUT_DATA_W = 8;

  // One segment pair as taken off the input bus
  typedef struct packed {
    logic [31:0] a1x;
    logic [30:0] a1y;
    logic [31:0] a2x;
    logic [30:0] a2y;
    logic [31:0] b1x;
    logic [30:0] b1y;
    logic [31:0] b2x;
    logic [30:0] b2y;
  } coords_t;

  // Stage 1: edge vectors, point offsets, endpoint match and box flags.
  // Offsets: 0 = A start vs B start, 1 = A end vs B start,
  //          2 = B start vs A start, 3 = B end vs A start.
  typedef struct packed {
    logic [32:0]       bdx;
    logic [31:0]       bdy;
    logic [32:0]       adx;
    logic [31:0]       ady;
    logic [3:0][32:0]  offx;
    logic [3:0][31:0]  offy;
    logic              shared;
    logic [3:0]        in_box;
  } prep_t;

  // Stage 2: the two products of each cross product
  typedef struct packed {
    logic [3:0][64:0] pa;
    logic [3:0][64:0] pb;
    logic             shared;
    logic [3:0]       in_box;
  } prod_t;

  // Stage 3: the four exact cross products
  typedef struct packed {
    logic [3:0][65:0] d;
    logic             shared;
    logic [3:0]       in_box;
  } cross_t;

endpackage

// File: rtl/sit_prep.sv
// First pipeline stage: coordinate differences, shared endpoints, box tests.
// Depends on sit_pkg.
module sit_prep (
  input  logic            clk,
  input  logic            en,
  input  sit_pkg::coords_t coords,
  input  logic [15:0]     box_tol,
  output sit_pkg::prep_t  prep_r
);

  sit_pkg::prep_t prep_nxt;

  // Point p inside box of (s, e) widened by t on every side
  function automatic logic box_ok(
    input logic signed [33:0] sx, input logic signed [33:0] ex,
    input logic signed [33:0] px,
    input logic signed [32:0] sy, input logic signed [32:0] ey,
    input logic signed [32:0] py,
    input logic [15:0] t
  );
    logic signed [33:0] pxh;
    logic signed [33:0] pxl;
    logic signed [32:0] pyh;
    logic signed [32:0] pyl;
    logic               okx;
    logic               oky;
    pxh = px + $signed({18'd0, t});
    pxl = px - $signed({18'd0, t});
    pyh = py + $signed({17'd0, t});
    pyl = py - $signed({17'd0, t});
    okx = ((sx <= pxh) || (ex <= pxh)) && ((pxl <= sx) || (pxl <= ex));
    oky = ((sy <= pyh) || (ey <= pyh)) && ((pyl <= sy) || (pyl <= ey));
    return okx && oky;
  endfunction

  always_comb begin
    logic signed [33:0] a1x, a2x, b1x, b2x;
    logic signed [32:0] a1y, a2y, b1y, b2y;
    a1x = $signed({{2{coords.a1x[31]}}, coords.a1x});
    a2x = $signed({{2{coords.a2x[31]}}, coords.a2x});
    b1x = $signed({{2{coords.b1x[31]}}, coords.b1x});
    b2x = $signed({{2{coords.b2x[31]}}, coords.b2x});
    a1y = $signed({{2{coords.a1y[30]}}, coords.a1y});
    a2y = $signed({{2{coords.a2y[30]}}, coords.a2y});
    b1y = $signed({{2{coords.b1y[30]}}, coords.b1y});
    b2y = $signed({{2{coords.b2y[30]}}, coords.b2y});

    // Edge vectors and offsets from each edge's start point
    prep_nxt.bdx     = 33'(b2x - b1x);
    prep_nxt.bdy     = 32'(b2y - b1y);
    prep_nxt.adx     = 33'(a2x - a1x);
    prep_nxt.ady     = 32'(a2y - a1y);
    prep_nxt.offx[0] = 33'(a1x - b1x);
    prep_nxt.offy[0] = 32'(a1y - b1y);
    prep_nxt.offx[1] = 33'(a2x - b1x);
    prep_nxt.offy[1] = 32'(a2y - b1y);
    prep_nxt.offx[2] = 33'(b1x - a1x);
    prep_nxt.offy[2] = 32'(b1y - a1y);
    prep_nxt.offx[3] = 33'(b2x - a1x);
    prep_nxt.offy[3] = 32'(b2y - a1y);

    // Any endpoint of A equal to any endpoint of B
    prep_nxt.shared = (a1x == b1x && a1y == b1y) || (a1x == b2x && a1y == b2y) ||
                      (a2x == b1x && a2y == b1y) || (a2x == b2x && a2y == b2y);

    // Widened bounding box tests, one per endpoint
    prep_nxt.in_box[0] = box_ok(b1x, b2x, a1x, b1y, b2y, a1y, box_tol);
    prep_nxt.in_box[1] = box_ok(b1x, b2x, a2x, b1y, b2y, a2y, box_tol);
    prep_nxt.in_box[2] = box_ok(a1x, a2x, b1x, a1y, a2y, b1y, box_tol);
    prep_nxt.in_box[3] = box_ok(a1x, a2x, b2x, a1y, a2y, b2y, box_tol);
  end

  // Advance the stage register
  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

endmodule

// File: rtl/sit_cross.sv
// Second and third pipeline stages: eight signed products, then four
// cross products as their differences. Depends on sit_pkg.
module sit_cross (
  input  logic            clk,
  input  logic            en_mul,
  input  logic            en_sub,
  input  sit_pkg::prep_t  prep,
  output sit_pkg::cross_t cross_r
);

  sit_pkg::prod_t  prod_nxt;
  sit_pkg::prod_t  prod_r;
  sit_pkg::cross_t cross_nxt;

  // Form (edge x) * (offset y) and (edge y) * (offset x) for each point
  always_comb begin
    logic signed [32:0] ex;
    logic signed [31:0] ey;
    logic signed [32:0] ox;
    logic signed [31:0] oy;
    logic signed [64:0] pa;
    logic signed [64:0] pb;
    prod_nxt.shared = prep.shared;
    prod_nxt.in_box = prep.in_box;
    for (int k = 0; k < 4; k++) begin
      ex = (k < 2) ? $signed(prep.bdx) : $signed(prep.adx);
      ey = (k < 2) ? $signed(prep.bdy) : $signed(prep.ady);
      ox = $signed(prep.offx[k]);
      oy = $signed(prep.offy[k]);
      pa = 65'(ex * oy);
      pb = 65'(ey * ox);
      prod_nxt.pa[k] = pa;
      prod_nxt.pb[k] = pb;
    end
  end

  // Subtract the product pairs at full width
  always_comb begin
    cross_nxt.shared = prod_r.shared;
    cross_nxt.in_box = prod_r.in_box;
    for (int k = 0; k < 4; k++) begin
      cross_nxt.d[k] = {prod_r.pa[k][64], prod_r.pa[k]} -
                       {prod_r.pb[k][64], prod_r.pb[k]};
    end
  end

  // Advance the product and difference registers
  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_r <= prod_nxt;
    end
    if (en_sub) begin
      cross_r <= cross_nxt;
    end
  end

endmodule

// File: rtl/sit_decide.sv
// Final decision: signs of the cross products, collinear tolerance and
// the combined verdict. Depends on sit_pkg.
module sit_decide (
  input  sit_pkg::cross_t cross_in,
  input  logic [31:0]     cross_tol,
  output logic            hit
);

  logic [3:0] neg;
  logic [3:0] pos;
  logic [3:0] near;
  logic       proper;

  always_comb begin
    logic signed [65:0] tol_w;
    logic signed [65:0] ntol_w;
    tol_w  = $signed({34'd0, cross_tol});
    ntol_w = -tol_w;
    for (int k = 0; k < 4; k++) begin
      neg[k] = cross_in.d[k][65];
      pos[k] = !cross_in.d[k][65] && (cross_in.d[k] != '0);
      // |d| <= tol without forming the magnitude
      near[k] = neg[k] ? ($signed(cross_in.d[k]) >= ntol_w)
                       : ($signed(cross_in.d[k]) <= tol_w);
    end
    // Strictly opposite sides on both pairs
    proper = ((pos[0] && neg[1]) || (neg[0] && pos[1])) &&
             ((pos[2] && neg[3]) || (neg[2] && pos[3]));
    hit = cross_in.shared || proper || |(near & cross_in.in_box);
  end

endmodule

// File: rtl/segment_intersection_test.sv
// Planar segment intersection test, streaming, one segment pair per item.
// Depends on sit_pkg, sit_prep, sit_cross and sit_decide.
//
// Input channel in_*: each item carries segment A and segment B as signed
// fixed-point endpoints. Output channel out_*: one item per input item,
// in order, with out_tdata[0] = 1 when the segments share a point, within the set tolerances.
// The APB port cfg_* sets the collinear tolerance (address 0) and the
// bounding box widening (address 4); write them only while no item is
// in flight.
// Pipeline: four register stages (differences and box tests, products,
// cross product subtraction, verdict); the result of an item passes
// through them in that order to out_*, and a stall may hold it in any stage.
// Throughput: one item per cycle while the receiver does not stall; the 33 x 32 bit product
// stage sets the clock, with eight such multipliers side by side.
// Reset clears all valid bits and both tolerance registers to zero.
// When the receiver stalls, the stages fill up one by one, and in_tready
// falls only once every stage holds an item; nothing is lost or repeated.
module segment_intersection_test (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // a_start_lng[31:0], a_start_lat[62:32], a_end_lng[94:63],
  // a_end_lat[125:95], b_start_lng[157:126], b_start_lat[188:158],
  // b_end_lng[220:189], b_end_lat[251:221], zero[255:252]
  input  logic [255:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // intersects[0], zero[7:1]
  output logic [7:0]  out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] cross_tol_r;
  logic [15:0] box_tol_r;
  logic        cfg_wr;

  sit_pkg::coords_t coords;
  sit_pkg::prep_t   prep_r;
  sit_pkg::cross_t  cross_r;

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic en1, en2, en3, en4;
  logic hit;
  logic hit_r;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cross_tol_r <= '0;
      box_tol_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        sit_pkg::REG_CROSS_TOL: cross_tol_r <= cfg_pwdata;
        sit_pkg::REG_BOX_TOL:   box_tol_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      sit_pkg::REG_CROSS_TOL: cfg_prdata = cross_tol_r;
      sit_pkg::REG_BOX_TOL:   cfg_prdata = {16'd0, box_tol_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // Unpack the input item
  assign coords.a1x = in_tdata[31:0];
  assign coords.a1y = in_tdata[62:32];
  assign coords.a2x = in_tdata[94:63];
  assign coords.a2y = in_tdata[125:95];
  assign coords.b1x = in_tdata[157:126];
  assign coords.b1y = in_tdata[188:158];
  assign coords.b2x = in_tdata[220:189];
  assign coords.b2y = in_tdata[251:221];

  // A stage loads when it is empty or its contents move on
  assign en4 = !out_valid_r || out_tready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r        <= in_tvalid;
      if (en2) v2_r        <= v1_r;
      if (en3) v3_r        <= v2_r;
      if (en4) out_valid_r <= v3_r;
    end
  end

  sit_prep u_prep (
    .clk     (clk),
    .en      (en1),
    .coords  (coords),
    .box_tol (box_tol_r),
    .prep_r  (prep_r)
  );

  sit_cross u_cross (
    .clk     (clk),
    .en_mul  (en2),
    .en_sub  (en3),
    .prep    (prep_r),
    .cross_r (cross_r)
  );

  sit_decide u_decide (
    .cross_in  (cross_r),
    .cross_tol (cross_tol_r),
    .hit       (hit)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (en4) begin
      hit_r <= hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, hit_r};

  // A shared endpoint always yields a hit
  a_shared_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && en4 && cross_r.shared) |=> out_tdata[0])
    else $error("shared endpoint did not report intersection");

  // Back-pressure reaches the input only with every stage full
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && out_valid_r))
    else $error("input stalled with an empty stage");

  // A held stage keeps its item
  a_hold_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !en3) |=> v2_r)
    else $error("product stage dropped an item");

  // An accepted item enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted item lost at entry");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for segment_intersection_test: streams segment pairs,
// predicts the intersects bit from its own fixed-point geometry model.
// Depends on rtl/sit_pkg.sv and rtl/segment_intersection_test.sv.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [2:0] ADDR_CROSS_TOL = {sit_pkg::REG_CROSS_TOL, 2'b00};
  localparam logic [2:0] ADDR_BOX_TOL   = {sit_pkg::REG_BOX_TOL, 2'b00};
  localparam longint     LNG_LIM        = 64'sd1509949440;
  localparam longint     LAT_LIM        = 64'sd754974720;

  typedef struct {
    logic signed [31:0] a1x;
    logic signed [30:0] a1y;
    logic signed [31:0] a2x;
    logic signed [30:0] a2y;
    logic signed [31:0] b1x;
    logic signed [30:0] b1y;
    logic signed [31:0] b2x;
    logic signed [30:0] b2y;
  } seg_pair_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  // Local copy of the tolerance registers
  bit [31:0] cross_tol_q;
  bit [15:0] box_tol_q;

  // Expected intersects bits, oldest first
  bit intersect_q[$];
  int err_count;
  int result_count;

  // Pacing knobs for both sides
  int tx_max_gap;
  int tx_max_burst = 1;
  int tx_burst_left;
  int rx_stall_max;
  int rx_run;
  bit rx_ready_phase;

  segment_intersection_test u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Orientation of p against the line s->e, exact at 128 bits
  function automatic logic signed [127:0] orient(longint sx, longint sy, longint ex,
                                                 longint ey, longint px, longint py);
    logic signed [127:0] ux, uy, vx, vy;
    ux = ex - sx;
    uy = ey - sy;
    vx = px - sx;
    vy = py - sy;
    return ux * vy - uy * vx;
  endfunction

  function automatic bit near_collinear(logic signed [127:0] d);
    logic [127:0] mag;
    mag = (d < 0) ? -d : d;
    return mag <= 128'(cross_tol_q);
  endfunction

  // Point inside the s-e bounding box widened by the box tolerance
  function automatic bit within_box(longint sx, longint sy, longint ex, longint ey,
                                    longint px, longint py);
    longint t, lox, hix, loy, hiy;
    t   = longint'(box_tol_q);
    lox = (sx < ex) ? sx : ex;
    hix = (sx > ex) ? sx : ex;
    loy = (sy < ey) ? sy : ey;
    hiy = (sy > ey) ? sy : ey;
    return (lox - t <= px) && (px <= hix + t) && (loy - t <= py) && (py <= hiy + t);
  endfunction

  function automatic bit predict_intersects(seg_pair_t p);
    longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic signed [127:0] d [4];
    bit cross_a, cross_b;
    ax1 = longint'(p.a1x);
    ay1 = longint'(p.a1y);
    ax2 = longint'(p.a2x);
    ay2 = longint'(p.a2y);
    bx1 = longint'(p.b1x);
    by1 = longint'(p.b1y);
    bx2 = longint'(p.b2x);
    by2 = longint'(p.b2y);
    // Shared endpoint decides at once
    if ((ax1 == bx1 && ay1 == by1) || (ax1 == bx2 && ay1 == by2) ||
        (ax2 == bx1 && ay2 == by1) || (ax2 == bx2 && ay2 == by2)) begin
      return 1'b1;
    end
    d[0] = orient(bx1, by1, bx2, by2, ax1, ay1);
    d[1] = orient(bx1, by1, bx2, by2, ax2, ay2);
    d[2] = orient(ax1, ay1, ax2, ay2, bx1, by1);
    d[3] = orient(ax1, ay1, ax2, ay2, bx2, by2);
    cross_a = (d[0] > 0 && d[1] < 0) || (d[0] < 0 && d[1] > 0);
    cross_b = (d[2] > 0 && d[3] < 0) || (d[2] < 0 && d[3] > 0);
    if (cross_a && cross_b) begin
      return 1'b1;
    end
    // Endpoint touching the other segment within tolerance
    return (near_collinear(d[0]) && within_box(bx1, by1, bx2, by2, ax1, ay1)) ||
           (near_collinear(d[1]) && within_box(bx1, by1, bx2, by2, ax2, ay2)) ||
           (near_collinear(d[2]) && within_box(ax1, ay1, ax2, ay2, bx1, by1)) ||
           (near_collinear(d[3]) && within_box(ax1, ay1, ax2, ay2, bx2, by2));
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic seg_pair_t pair_of(longint a1x, longint a1y, longint a2x, longint a2y,
                                        longint b1x, longint b1y, longint b2x, longint b2y);
    seg_pair_t p;
    p.a1x = a1x[31:0];
    p.a1y = a1y[30:0];
    p.a2x = a2x[31:0];
    p.a2y = a2y[30:0];
    p.b1x = b1x[31:0];
    p.b1y = b1y[30:0];
    p.b2x = b2x[31:0];
    p.b2y = b2y[30:0];
    return p;
  endfunction

  function automatic longint rand_span(longint lim);
    return longint'($urandom_range(32'(2 * lim), 0)) - lim;
  endfunction

  // Random step with a random order of magnitude
  function automatic longint rand_step();
    return rand_span(longint'(1) << $urandom_range(20, 0));
  endfunction

  // Mostly well-formed geometry (touching, shared, collinear, clustered),
  // the rest plain random and raw bit patterns
  function automatic seg_pair_t gen_pair();
    longint c [8];
    longint sx, sy, dx, dy, t, tmp;
    int pick, m, k, i, j;
    pick = $urandom_range(9, 0);
    sx = rand_span(LNG_LIM);
    sy = rand_span(LAT_LIM);
    dx = rand_step();
    dy = rand_step();
    case (pick)
      0: begin
        // raw bit patterns, out of range included
        for (i = 0; i < 8; i++) c[i] = longint'($urandom);
      end
      1: begin
        for (i = 0; i < 8; i++) c[i] = (i % 2 == 0) ? rand_span(LNG_LIM) : rand_span(LAT_LIM);
      end
      2, 3: begin
        // tight cluster: degenerate and collinear cases are common
        for (i = 0; i < 8; i++) c[i] = ((i % 2 == 0) ? sx : sy) + rand_span(3);
      end
      4, 5, 6: begin
        // B start lies on segment A, possibly at an end
        m = $urandom_range(8, 1);
        k = $urandom_range(m, 0);
        c[0] = sx;
        c[1] = sy;
        c[2] = sx + m * dx;
        c[3] = sy + m * dy;
        c[4] = sx + k * dx;
        c[5] = sy + k * dy;
        c[6] = c[4] + rand_step();
        c[7] = c[5] + rand_step();
      end
      7: begin
        // copy one endpoint of A onto one endpoint of B
        for (i = 0; i < 8; i++) c[i] = (i % 2 == 0) ? rand_span(LNG_LIM) : rand_span(LAT_LIM);
        i = $urandom_range(1, 0);
        j = $urandom_range(1, 0);
        c[4 + 2 * j] = c[2 * i];
        c[5 + 2 * j] = c[2 * i + 1];
      end
      default: begin
        // all four points on one line
        for (i = 0; i < 4; i++) begin
          t = rand_span(6);
          c[2 * i]     = sx + t * dx;
          c[2 * i + 1] = sy + t * dy;
        end
      end
    endcase
    // Nudge one coordinate now and then to land near the tolerances
    if ($urandom_range(2, 0) == 0) begin
      i = $urandom_range(7, 0);
      c[i] += rand_span(longint'(1) << $urandom_range(6, 0));
    end
    // Shuffle roles so every endpoint position sees each case
    if ($urandom_range(1, 0) == 1) begin
      for (i = 0; i < 4; i++) begin
        tmp = c[i];
        c[i] = c[i + 4];
        c[i + 4] = tmp;
      end
    end
    if ($urandom_range(1, 0) == 1) begin
      tmp = c[0]; c[0] = c[2]; c[2] = tmp;
      tmp = c[1]; c[1] = c[3]; c[3] = tmp;
    end
    if ($urandom_range(1, 0) == 1) begin
      tmp = c[4]; c[4] = c[6]; c[6] = tmp;
      tmp = c[5]; c[5] = c[7]; c[7] = tmp;
    end
    return pair_of(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  // ---------------------------------------------------------------------
  // Bus drivers
  // ---------------------------------------------------------------------

  // Offer one item, hold until accepted, then apply the burst/gap pacing
  task automatic send_pair(input seg_pair_t p);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, p.b2y, p.b2x, p.b1y, p.b1x, p.a2y, p.a2x, p.a1y, p.a1x};
    do @(posedge clk); while (!in_tready);
    intersect_q.push_back(predict_intersects(p));
    if (tx_burst_left > 0) begin
      tx_burst_left--;
    end else begin
      tx_burst_left = $urandom_range(tx_max_burst, 0);
      gap = (tx_max_gap > 0) ? $urandom_range(tx_max_gap, 0) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pair(gen_pair());
  endtask

  task automatic set_idling(input int max_gap, input int max_burst, input int stall_max);
    tx_max_gap    = max_gap;
    tx_max_burst  = max_burst;
    tx_burst_left = 0;
    rx_stall_max  = stall_max;
  endtask

  // Stop offering items and wait out every pending result
  task automatic drain_results();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (intersect_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    if (intersect_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", intersect_q.size()));
      intersect_q.delete();
    end
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_CROSS_TOL) cross_tol_q = value;
    else if (addr == ADDR_BOX_TOL) box_tol_q = value[15:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [2:0] addr);
    logic [31:0] want;
    want = (addr == ADDR_BOX_TOL) ? {16'b0, box_tol_q} : cross_tol_q;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      report_mismatch($sformatf("register at %0d reads %h, expected %h", addr, cfg_prdata,
                                want));
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_tolerances(input logic [31:0] cross_tol, input logic [15:0] box_tol);
    drain_results();
    write_reg(ADDR_CROSS_TOL, cross_tol);
    write_reg(ADDR_BOX_TOL, {16'b0, box_tol});
    check_reg(ADDR_CROSS_TOL);
    check_reg(ADDR_BOX_TOL);
  endtask

  // ---------------------------------------------------------------------
  // Receiver and result check
  // ---------------------------------------------------------------------

  // Alternate ready and stall runs of random length
  always @(posedge clk) begin
    if (rx_stall_max == 0) begin
      out_tready <= 1'b1;
    end else if (rx_run == 0) begin
      rx_ready_phase = !rx_ready_phase;
      rx_run = rx_ready_phase ? $urandom_range(12, 1) : $urandom_range(rx_stall_max, 1);
      out_tready <= rx_ready_phase;
    end else begin
      rx_run--;
    end
  end

  always @(posedge clk) begin : check_results
    bit want;
    if (rst_n && out_tvalid && out_tready) begin
      if (intersect_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item pending", result_count));
      end else begin
        want = intersect_q.pop_front();
        if (out_tdata !== {7'b0, want}) begin
          report_mismatch($sformatf("result %0d: out_tdata %h, expected intersects %0b",
                                    result_count, out_tdata, want));
        end
      end
      result_count++;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_register_access();
    check_reg(ADDR_CROSS_TOL);
    check_reg(ADDR_BOX_TOL);
    write_reg(ADDR_CROSS_TOL, 32'hFFFF_FFFF);
    // upper bits beyond the box register width are dropped
    write_reg(ADDR_BOX_TOL, 32'h5A5A_FFFF);
    check_reg(ADDR_CROSS_TOL);
    check_reg(ADDR_BOX_TOL);
  endtask

  task automatic test_directed_pairs();
    set_tolerances(32'd0, 16'd0);
    set_idling(0, 0, 0);
    // shared endpoints, each combination
    send_pair(pair_of(0, 0, 10, 0, 0, 0, 0, 10));
    send_pair(pair_of(5, 5, 9, 1, -3, 2, 5, 5));
    send_pair(pair_of(-3, 2, 5, 5, 5, 5, 9, 1));
    send_pair(pair_of(1, 1, 7, -4, 2, 9, 7, -4));
    // proper crossing, parallel, collinear overlap and gap
    send_pair(pair_of(0, 0, 10, 10, 0, 10, 10, 0));
    send_pair(pair_of(0, 0, 10, 0, 0, 1, 10, 1));
    send_pair(pair_of(0, 0, 10, 0, 5, 0, 15, 0));
    send_pair(pair_of(0, 0, 4, 0, 6, 0, 9, 0));
    // one endpoint on the other segment's interior, each position
    send_pair(pair_of(5, 0, 5, 7, 0, 0, 10, 0));
    send_pair(pair_of(5, 7, 5, 0, 0, 0, 10, 0));
    send_pair(pair_of(0, 0, 10, 0, 5, 0, 5, 7));
    send_pair(pair_of(0, 0, 10, 0, 5, 7, 5, 0));
    // degenerate segments
    send_pair(pair_of(3, 3, 3, 3, 0, 0, 6, 6));
    send_pair(pair_of(1, 1, 1, 1, 2, 2, 2, 2));
    send_pair(pair_of(4, -4, 4, -4, 4, -4, 4, -4));
    // miss by one unit
    send_pair(pair_of(5, 1, 5, 7, 0, 0, 10, 0));
    // corners of the legal range
    send_pair(pair_of(-LNG_LIM, -LAT_LIM, LNG_LIM, LAT_LIM, -LNG_LIM, LAT_LIM, LNG_LIM, -LAT_LIM));
    send_pair(pair_of(LNG_LIM, LAT_LIM, LNG_LIM, -LAT_LIM,
                      LNG_LIM - 1, LAT_LIM, LNG_LIM - 1, -LAT_LIM));
    // extremes of the field encodings
    send_pair(pair_of(64'sd2147483647, 64'sd1073741823, -64'sd2147483648, -64'sd1073741824,
                      -64'sd2147483648, 64'sd1073741823, 64'sd2147483647, -64'sd1073741824));
    send_pair(pair_of(-1, -1, 0, 0, -1, 0, 0, -1));
    send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    drain_results();
  endtask

  task automatic test_random_exact();
    set_tolerances(32'd0, 16'd0);
    set_idling(4, 6, 6);
    send_random(250);
    // hold the sender until the pipeline is empty, then resume
    drain_results();
    send_random(250);
  endtask

  task automatic test_tolerance_sweep();
    set_tolerances(32'd1, 16'd1);
    set_idling(2, 10, 3);
    send_random(250);
    set_tolerances(32'hFFFF_FFFF, 16'd0);
    set_idling(6, 3, 0);
    send_random(250);
    set_tolerances(32'd0, 16'hFFFF);
    set_idling(0, 1, 8);
    send_random(250);
    set_tolerances(32'd1000, 16'd3);
    set_idling(3, 4, 2);
    send_random(250);
    set_tolerances(32'hFFFF_FFFF, 16'hFFFF);
    set_idling(5, 8, 5);
    send_random(250);
  endtask

  task automatic test_back_to_back();
    set_tolerances(32'h0001_0000, 16'd7);
    set_idling(0, 1, 0);
    send_random(150);
  endtask

  initial begin : run_tests
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_directed_pairs();
    test_random_exact();
    test_tolerance_sweep();
    test_back_to_back();
    drain_results();
    if (err_count == 0) begin
      $display("PASS segment_intersection_test");
    end else begin
      $display("FAIL segment_intersection_test");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL segment_intersection_test");
    $finish;
  end

endmodule

// File: files.f
rtl/sit_pkg.sv
rtl/sit_prep.sv
rtl/sit_cross.sv
rtl/sit_decide.sv
rtl/segment_intersection_test.sv
tb/tb_top.sv
